// File: rtl/cffrf_pkg.sv
package cffrf_pkg;

   // Table sizes
   localparam int ALLOW_ENTRIES  = 32;
   localparam int CATCHALL_SLOTS = 128;

   localparam int ALLOW_AW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
   localparam int ALLOW_CW = $clog2(ALLOW_ENTRIES + 1);
   localparam int CA_AW    = $clog2(CATCHALL_SLOTS);

   // Field widths
   localparam int BUS_W  = 2;
   localparam int ID_W   = 29;
   localparam int TIME_W = 32;
   localparam int SLOT_W = 5;
   localparam int KEY_W  = BUS_W + ID_W;

   localparam int HASH_SHIFT = 15;

   localparam logic [BUS_W-1:0] BUS_ANY = '0;

   // Request kind carried in tuser
   localparam logic ACT_JUDGE = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Decision source codes
   localparam logic [1:0] DEC_NONE  = 2'd0;
   localparam logic [1:0] DEC_ALLOW = 2'd1;
   localparam logic [1:0] DEC_CATCH = 2'd2;

   // Control register indexes
   localparam logic CSR_ENABLE   = 1'b0;
   localparam logic CSR_INTERVAL = 1'b1;

   localparam logic        ENABLE_RESET   = 1'b1;
   localparam logic [31:0] INTERVAL_RESET = 32'd1000;

   // Request payload, lowest field last
   typedef struct packed {
      logic [3:0]        pad;
      logic [TIME_W-1:0] entry_interval_ms;
      logic [ID_W-1:0]   entry_id;
      logic [BUS_W-1:0]  entry_bus;
      logic              entry_valid;
      logic [SLOT_W-1:0] entry_slot;
      logic [TIME_W-1:0] timestamp_ms;
      logic [ID_W-1:0]   frame_id;
      logic [BUS_W-1:0]  frame_bus;
   } req_type;

   // Allow-list memory word
   typedef struct packed {
      logic [TIME_W-1:0] interval;
      logic [ID_W-1:0]   id;
      logic [BUS_W-1:0]  bus;
      logic [TIME_W-1:0] last;
   } allow_word_type;

   // Catch-all memory word
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] last;
   } ca_word_type;

   // Fold the key onto a catch-all slot
   function automatic logic [CA_AW-1:0] ca_hash(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] mix;
      mix = key ^ (key >> HASH_SHIFT);
      return CA_AW'(mix % CATCHALL_SLOTS);
   endfunction

endpackage

// File: rtl/can_frame_forward_rate_filter_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser: action; tdata: frame and entry fields
// rsp_      out        rsp_tvalid/rsp_tready  tdata: forward, decided_by
// csr_      in         csr_wen                csr_index, csr_wdata
//
// An entry write goes from accept through the write and done states to its result. A frame
// judgement scans the allow-list memory one entry per cycle through its single read port:
// a hit then takes the allow state, a miss the catch-all read and decide states if enabled.
// Reset (synchronous) clears the valid bits of both tables directly; no clearing pass.
// A new request is taken once the previous result sits in the output register; a stalled
// result holds the block in its final state until the output register frees up.
module can_frame_forward_rate_filter_unit (
   input  logic          clock,
   input  logic          reset,
   // Request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,  // frame_bus, frame_id, timestamp_ms, entry_slot,
                                     // entry_valid, entry_bus, entry_id, entry_interval_ms
   input  logic          req_tuser,  // action
   // Result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,  // forward, decided_by
   // Control register port
   input  logic          csr_wen,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_WRITE     = 3'd1;
   localparam logic [2:0] ST_SCAN      = 3'd2;
   localparam logic [2:0] ST_ALLOW     = 3'd3;
   localparam logic [2:0] ST_CA_READ   = 3'd4;
   localparam logic [2:0] ST_CA_DECIDE = 3'd5;
   localparam logic [2:0] ST_DONE      = 3'd6;

   localparam logic [cffrf_pkg::ALLOW_AW-1:0] LAST_TAG =
      cffrf_pkg::ALLOW_AW'(cffrf_pkg::ALLOW_ENTRIES - 1);

   logic [2:0]                        state_ff, state_in;
   cffrf_pkg::req_type                req_ff;
   logic                              act_ff;
   logic [cffrf_pkg::ALLOW_CW-1:0]    scan_cnt_ff, scan_cnt_in;
   logic                              rd_vld_ff;
   logic [cffrf_pkg::ALLOW_AW-1:0]    rd_tag_ff;
   cffrf_pkg::allow_word_type         rd_data_ff;
   cffrf_pkg::ca_word_type            ca_data_ff;
   logic [cffrf_pkg::ALLOW_ENTRIES-1:0]  allow_vld_ff;
   logic [cffrf_pkg::CATCHALL_SLOTS-1:0] ca_vld_ff;
   logic                              res_fwd_ff, res_fwd_in;
   logic [1:0]                        res_dec_ff, res_dec_in;
   logic                              rsp_valid_ff;
   logic                              rsp_fwd_ff;
   logic [1:0]                        rsp_dec_ff;
   logic                              en_ff;
   logic [31:0]                       ivl_ff;

   cffrf_pkg::allow_word_type allow_mem [cffrf_pkg::ALLOW_ENTRIES];
   cffrf_pkg::ca_word_type    ca_mem    [cffrf_pkg::CATCHALL_SLOTS];

   logic                              req_acc;
   logic                              slot_ok;
   logic [cffrf_pkg::ALLOW_AW-1:0]    slot_idx;
   logic                              scan_issue;
   logic                              scan_hit;
   logic                              scan_end;
   logic [cffrf_pkg::TIME_W-1:0]      al_elapsed;
   logic                              al_fwd;
   logic                              al_wen;
   logic [cffrf_pkg::ALLOW_AW-1:0]    al_waddr;
   cffrf_pkg::allow_word_type         al_wdata;
   logic [cffrf_pkg::KEY_W-1:0]       ca_key;
   logic [cffrf_pkg::CA_AW-1:0]       ca_idx;
   logic                              ca_same;
   logic [cffrf_pkg::TIME_W-1:0]      ca_elapsed;
   logic                              ca_fwd;
   logic                              ca_wen;
   logic                              rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_dec_ff, rsp_fwd_ff};

   // Entry write target
   assign slot_ok  = (32'(req_ff.entry_slot) < cffrf_pkg::ALLOW_ENTRIES);
   assign slot_idx = cffrf_pkg::ALLOW_AW'(req_ff.entry_slot);

   // Allow-list scan: one read issued per cycle, compared when the data returns
   assign scan_hit = (state_ff == ST_SCAN) && rd_vld_ff && allow_vld_ff[rd_tag_ff] &&
                     (rd_data_ff.id == req_ff.frame_id) &&
                     ((rd_data_ff.bus == cffrf_pkg::BUS_ANY) ||
                      (rd_data_ff.bus == req_ff.frame_bus));
   assign scan_issue = (state_ff == ST_SCAN) && !scan_hit &&
                       (scan_cnt_ff < cffrf_pkg::ALLOW_CW'(cffrf_pkg::ALLOW_ENTRIES));
   assign scan_end   = (state_ff == ST_SCAN) && rd_vld_ff && !scan_hit &&
                       (rd_tag_ff == LAST_TAG);

   // Rate check for the matching entry
   assign al_elapsed = req_ff.timestamp_ms - rd_data_ff.last;
   assign al_fwd     = (rd_data_ff.interval == '0) || (al_elapsed >= rd_data_ff.interval);

   // Catch-all lookup
   assign ca_key     = {req_ff.frame_bus, req_ff.frame_id};
   assign ca_idx     = cffrf_pkg::ca_hash(ca_key);
   assign ca_same    = ca_vld_ff[ca_idx] && (ca_data_ff.key == ca_key);
   assign ca_elapsed = req_ff.timestamp_ms - ca_data_ff.last;
   assign ca_fwd     = !ca_same || (ca_elapsed >= ivl_ff);
   assign ca_wen     = (state_ff == ST_CA_DECIDE) && ca_fwd;

   // Allow-list write port: entry load or stamp update
   always_comb begin
      al_wen   = 1'b0;
      al_waddr = rd_tag_ff;
      al_wdata = rd_data_ff;
      if (state_ff == ST_WRITE) begin
         al_wen   = slot_ok;
         al_waddr = slot_idx;
         al_wdata = '{interval: req_ff.entry_interval_ms, id: req_ff.entry_id,
                      bus: req_ff.entry_bus, last: '0};
      end else if (state_ff == ST_ALLOW) begin
         al_wen        = al_fwd && (rd_data_ff.interval != '0);
         al_wdata.last = req_ff.timestamp_ms;
      end
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      res_fwd_in  = res_fwd_ff;
      res_dec_in  = res_dec_ff;
      if (scan_issue) begin
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               scan_cnt_in = '0;
               state_in    = (req_tuser == cffrf_pkg::ACT_WRITE) ? ST_WRITE : ST_SCAN;
            end
         end
         ST_WRITE: begin
            res_fwd_in = 1'b0;
            res_dec_in = cffrf_pkg::DEC_NONE;
            state_in   = ST_DONE;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_ALLOW;
            end else if (scan_end) begin
               if (en_ff) begin
                  state_in = ST_CA_READ;
               end else begin
                  res_fwd_in = 1'b0;
                  res_dec_in = cffrf_pkg::DEC_NONE;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_ALLOW: begin
            res_fwd_in = al_fwd;
            res_dec_in = cffrf_pkg::DEC_ALLOW;
            state_in   = ST_DONE;
         end
         ST_CA_READ: begin
            state_in = ST_CA_DECIDE;
         end
         ST_CA_DECIDE: begin
            res_fwd_in = ca_fwd;
            res_dec_in = cffrf_pkg::DEC_CATCH;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         allow_vld_ff <= '0;
         ca_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         en_ff        <= cffrf_pkg::ENABLE_RESET;
         ivl_ff       <= cffrf_pkg::INTERVAL_RESET;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= scan_issue;
         if ((state_ff == ST_WRITE) && slot_ok) begin
            allow_vld_ff[slot_idx] <= req_ff.entry_valid;
         end
         if (ca_wen) begin
            ca_vld_ff[ca_idx] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wen) begin
            unique case (csr_index)
               cffrf_pkg::CSR_ENABLE:   en_ff  <= csr_wdata[0];
               cffrf_pkg::CSR_INTERVAL: ivl_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      res_fwd_ff  <= res_fwd_in;
      res_dec_ff  <= res_dec_in;
      if (req_acc) begin
         req_ff <= cffrf_pkg::req_type'(req_tdata);
         act_ff <= req_tuser;
      end
      if (rsp_load) begin
         rsp_fwd_ff <= (act_ff == cffrf_pkg::ACT_WRITE) ? 1'b0 : res_fwd_ff;
         rsp_dec_ff <= res_dec_ff;
      end
   end

   // Allow-list memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (al_wen) begin
         allow_mem[al_waddr] <= al_wdata;
      end
      if (scan_issue) begin
         rd_data_ff <= allow_mem[scan_cnt_ff[cffrf_pkg::ALLOW_AW-1:0]];
         rd_tag_ff  <= scan_cnt_ff[cffrf_pkg::ALLOW_AW-1:0];
      end
   end

   // Catch-all memory: claim or stamp on forward, read once per lookup
   always_ff @(posedge clock) begin
      if (ca_wen) begin
         ca_mem[ca_idx] <= '{key: ca_key, last: req_ff.timestamp_ms};
      end
      if (state_ff == ST_CA_READ) begin
         ca_data_ff <= ca_mem[ca_idx];
      end
   end

endmodule

// File: tb/can_frame_forward_rate_filter_unit_tb.sv
module can_frame_forward_rate_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      logic       forward;
      logic [1:0] decided_by;
   } verdict_type;

   // Predicts the forward verdict of every request and checks results against it
   class forward_verdict_tracker;
      logic                         entry_valid    [cffrf_pkg::ALLOW_ENTRIES];
      logic [cffrf_pkg::BUS_W-1:0]  entry_bus      [cffrf_pkg::ALLOW_ENTRIES];
      logic [cffrf_pkg::ID_W-1:0]   entry_id       [cffrf_pkg::ALLOW_ENTRIES];
      logic [cffrf_pkg::TIME_W-1:0] entry_interval [cffrf_pkg::ALLOW_ENTRIES];
      logic [cffrf_pkg::TIME_W-1:0] entry_last     [cffrf_pkg::ALLOW_ENTRIES];
      logic                         slot_used      [cffrf_pkg::CATCHALL_SLOTS];
      logic [cffrf_pkg::KEY_W-1:0]  slot_key       [cffrf_pkg::CATCHALL_SLOTS];
      logic [cffrf_pkg::TIME_W-1:0] slot_last      [cffrf_pkg::CATCHALL_SLOTS];
      logic                         catchall_enable;
      logic [cffrf_pkg::TIME_W-1:0] catchall_interval;
      verdict_type                  pending_verdicts[$];
      int                           error_count;

      function new();
         foreach (entry_valid[i]) begin
            entry_valid[i]    = 1'b0;
            entry_bus[i]      = '0;
            entry_id[i]       = '0;
            entry_interval[i] = '0;
            entry_last[i]     = '0;
         end
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_last[i] = '0;
         end
         catchall_enable   = cffrf_pkg::ENABLE_RESET;
         catchall_interval = cffrf_pkg::INTERVAL_RESET;
         error_count       = 0;
      endfunction

      function void write_register(logic index, logic [31:0] value);
         if (index == cffrf_pkg::CSR_ENABLE) begin
            catchall_enable = value[0];
         end else begin
            catchall_interval = value;
         end
      endfunction

      // Apply one accepted request and queue the verdict it must produce
      function void note_request(logic action, cffrf_pkg::req_type r);
         verdict_type                    v;
         logic                           found;
         logic [cffrf_pkg::ALLOW_AW-1:0] hit;
         logic [cffrf_pkg::CA_AW-1:0]    slot;
         logic [cffrf_pkg::KEY_W-1:0]    key;
         logic [cffrf_pkg::KEY_W-1:0]    folded;
         logic [cffrf_pkg::TIME_W-1:0]   elapsed;
         v.forward    = 1'b0;
         v.decided_by = cffrf_pkg::DEC_NONE;
         found        = 1'b0;
         hit          = '0;
         if (action == cffrf_pkg::ACT_WRITE) begin
            // Entry write: store fields and clear the entry's last-forward time
            if (int'(r.entry_slot) < cffrf_pkg::ALLOW_ENTRIES) begin
               entry_valid[r.entry_slot]    = r.entry_valid;
               entry_bus[r.entry_slot]      = r.entry_bus;
               entry_id[r.entry_slot]       = r.entry_id;
               entry_interval[r.entry_slot] = r.entry_interval_ms;
               entry_last[r.entry_slot]     = '0;
            end
         end else begin
            // First valid matching entry in index order decides
            for (int i = 0; i < cffrf_pkg::ALLOW_ENTRIES && !found; i++) begin
               if (entry_valid[cffrf_pkg::ALLOW_AW'(i)] &&
                   entry_id[cffrf_pkg::ALLOW_AW'(i)] == r.frame_id &&
                   (entry_bus[cffrf_pkg::ALLOW_AW'(i)] == cffrf_pkg::BUS_ANY ||
                    entry_bus[cffrf_pkg::ALLOW_AW'(i)] == r.frame_bus)) begin
                  found = 1'b1;
                  hit   = cffrf_pkg::ALLOW_AW'(i);
               end
            end
            if (found) begin
               v.decided_by = cffrf_pkg::DEC_ALLOW;
               elapsed      = r.timestamp_ms - entry_last[hit];
               if (entry_interval[hit] == '0) begin
                  v.forward = 1'b1;
               end else if (elapsed >= entry_interval[hit]) begin
                  entry_last[hit] = r.timestamp_ms;
                  v.forward       = 1'b1;
               end
            end else if (catchall_enable) begin
               // Direct-mapped catch-all: same key is rate-limited, else claim the slot
               v.decided_by = cffrf_pkg::DEC_CATCH;
               key          = {r.frame_bus, r.frame_id};
               folded       = key ^ (key >> cffrf_pkg::HASH_SHIFT);
               slot         = cffrf_pkg::CA_AW'(folded % cffrf_pkg::CATCHALL_SLOTS);
               if (slot_used[slot] && slot_key[slot] == key) begin
                  elapsed = r.timestamp_ms - slot_last[slot];
                  if (elapsed >= catchall_interval) begin
                     slot_last[slot] = r.timestamp_ms;
                     v.forward       = 1'b1;
                  end
               end else begin
                  slot_used[slot] = 1'b1;
                  slot_key[slot]  = key;
                  slot_last[slot] = r.timestamp_ms;
                  v.forward       = 1'b1;
               end
            end
         end
         pending_verdicts.push_back(v);
      endfunction

      // Compare one result with the oldest pending verdict
      function void check_result(logic [7:0] data);
         verdict_type v;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with nothing pending: forward %0b decided_by %0d",
                     $time, data[0], data[2:1]);
            error_count++;
            return;
         end
         v = pending_verdicts.pop_front();
         if (data[0] !== v.forward) begin
            $display("%0t: forward mismatch: expected %0b actual %0b",
                     $time, v.forward, data[0]);
            error_count++;
         end
         if (data[2:1] !== v.decided_by) begin
            $display("%0t: decided_by mismatch: expected %0d actual %0d",
                     $time, v.decided_by, data[2:1]);
            error_count++;
         end
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata  = '0;
   logic         req_tuser  = cffrf_pkg::ACT_JUDGE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [7:0]   rsp_tdata;
   logic         csr_wen    = 1'b0;
   logic         csr_index  = cffrf_pkg::CSR_ENABLE;
   logic [31:0]  csr_wdata  = '0;

   forward_verdict_tracker verdicts;
   logic [cffrf_pkg::ID_W-1:0]   id_pool [8];
   logic [cffrf_pkg::TIME_W-1:0] now_ms;
   int                           sender_idle_pct    = 0;
   int                           receiver_stall_pct = 0;
   int                           quiet_cycles       = 0;

   can_frame_forward_rate_filter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Sample handshakes, track predictions, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            verdicts.note_request(req_tuser, cffrf_pkg::req_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            verdicts.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("can_frame_forward_rate_filter_unit_tb: done, errors");
            $finish;
         end
      end
   end

   function automatic cffrf_pkg::req_type random_payload();
      logic [159:0]       raw;
      cffrf_pkg::req_type r;
      raw   = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r     = raw[135:0];
      r.pad = '0;
      return r;
   endfunction

   // Hold a request until it is accepted; returns at a falling edge
   task automatic send_request(logic action, cffrf_pkg::req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_frame(logic [cffrf_pkg::BUS_W-1:0] bus,
                             logic [cffrf_pkg::ID_W-1:0] id,
                             logic [cffrf_pkg::TIME_W-1:0] stamp);
      cffrf_pkg::req_type r;
      r              = random_payload();
      r.frame_bus    = bus;
      r.frame_id     = id;
      r.timestamp_ms = stamp;
      send_request(cffrf_pkg::ACT_JUDGE, r);
   endtask

   task automatic send_entry(logic [cffrf_pkg::SLOT_W-1:0] slot, logic valid,
                             logic [cffrf_pkg::BUS_W-1:0] bus,
                             logic [cffrf_pkg::ID_W-1:0] id,
                             logic [cffrf_pkg::TIME_W-1:0] interval);
      cffrf_pkg::req_type r;
      r                   = random_payload();
      r.entry_slot        = slot;
      r.entry_valid       = valid;
      r.entry_bus         = bus;
      r.entry_id          = id;
      r.entry_interval_ms = interval;
      send_request(cffrf_pkg::ACT_WRITE, r);
   endtask

   // Drop valid and wait until every verdict has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (verdicts.pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_settings(logic enable, logic [31:0] interval);
      csr_wen   <= 1'b1;
      csr_index <= cffrf_pkg::CSR_ENABLE;
      csr_wdata <= {31'b0, enable};
      @(negedge clock);
      csr_index <= cffrf_pkg::CSR_INTERVAL;
      csr_wdata <= interval;
      @(negedge clock);
      csr_wen <= 1'b0;
      verdicts.write_register(cffrf_pkg::CSR_ENABLE, {31'b0, enable});
      verdicts.write_register(cffrf_pkg::CSR_INTERVAL, interval);
   endtask

   // Mostly listed identifiers, some hash collisions, some anything
   function automatic logic [cffrf_pkg::ID_W-1:0] pick_id();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)
         return id_pool[3'($urandom_range(7))];
      if (roll < 85)
         return id_pool[3'($urandom_range(7))] ^
                (cffrf_pkg::ID_W'($urandom_range(1, 127)) << 22);
      return cffrf_pkg::ID_W'($urandom);
   endfunction

   function automatic logic [cffrf_pkg::TIME_W-1:0] pick_interval();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) return '0;
      if (roll < 70) return $urandom_range(1, 40);
      if (roll < 80) return $urandom_range(500, 2000);
      if (roll < 92) return $urandom;
      return 32'hFFFF_FFFF;
   endfunction

   task automatic random_request();
      int roll;
      int step;
      roll = $urandom_range(99);
      if (roll < 12) begin
         send_entry(cffrf_pkg::SLOT_W'($urandom_range(31)), $urandom_range(99) < 85,
                    cffrf_pkg::BUS_W'($urandom_range(3)), pick_id(), pick_interval());
      end else begin
         // Advance the frame clock: small steps, jumps, wrap and repeats
         step = $urandom_range(99);
         if (step < 80)
            now_ms = now_ms + $urandom_range(0, 20);
         else if (step < 88)
            now_ms = now_ms + $urandom_range(0, 2000);
         else if (step < 93)
            now_ms = $urandom;
         else if (step < 97)
            now_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
         else
            now_ms = now_ms - $urandom_range(0, 5);
         send_frame(cffrf_pkg::BUS_W'($urandom_range(3)), pick_id(), now_ms);
      end
   endtask

   initial begin
      verdicts   = new();
      id_pool[0] = '0;
      id_pool[1] = 29'h1FFF_FFFF;
      for (int i = 2; i < 8; i++)
         id_pool[3'(i)] = (i % 2 == 0) ? cffrf_pkg::ID_W'($urandom_range(0, 2047)) :
                                         cffrf_pkg::ID_W'($urandom);
      now_ms = 32'd5000;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Catch-all at reset settings: empty slot with key zero, rate limit, eviction
      send_frame(2'd0, '0, 32'd0);
      send_frame(2'd0, '0, 32'd999);
      send_frame(2'd0, '0, 32'd1000);
      send_frame(2'd3, 29'h1FFF_FFFF, 32'hFFFF_FFFF);
      send_frame(2'd1, 29'h040_0000, 32'd5);
      send_frame(2'd0, '0, 32'd1001);
      // Unlimited entry on any bus
      send_entry(5'd0, 1'b1, cffrf_pkg::BUS_ANY, 29'h123, 32'd0);
      send_frame(2'd2, 29'h123, 32'd2000);
      send_frame(2'd0, 29'h123, 32'd2001);
      // Widest entry: bus mismatch falls through to the catch-all
      send_entry(5'd31, 1'b1, 2'd2, 29'h1FFF_FFFF, 32'hFFFF_FFFF);
      send_frame(2'd2, 29'h1FFF_FFFF, 32'd0);
      send_frame(2'd1, 29'h1FFF_FFFF, 32'd1);
      // Rate-limited entry, across the timestamp wrap
      send_entry(5'd5, 1'b1, 2'd1, 29'h7FF, 32'd10);
      send_frame(2'd1, 29'h7FF, 32'd5);
      send_frame(2'd1, 29'h7FF, 32'd10);
      send_frame(2'd1, 29'h7FF, 32'd19);
      send_frame(2'd1, 29'h7FF, 32'd20);
      send_frame(2'd1, 29'h7FF, 32'hFFFF_FFFA);
      send_frame(2'd1, 29'h7FF, 32'd4);
      // Invalid entry matches nothing
      send_entry(5'd0, 1'b0, cffrf_pkg::BUS_ANY, 29'h123, 32'd0);
      send_frame(2'd2, 29'h123, 32'd30);
      // Lower index wins; frame bus zero
      send_entry(5'd1, 1'b1, cffrf_pkg::BUS_ANY, 29'h7FF, 32'd0);
      send_frame(2'd1, 29'h7FF, 32'd5);
      send_frame(2'd0, 29'h7FF, 32'd6);
      send_frame(2'd0, 29'h1FFF_FFFF, 32'd7);
      // Catch-all disabled
      wait_drained();
      write_settings(1'b0, cffrf_pkg::INTERVAL_RESET);
      send_frame(2'd2, 29'h0AB_CDEF, 32'd8);
      send_frame(2'd1, 29'h7FF, 32'd9);

      // Random phases under different settings and idling
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         unique case (phase)
            0: write_settings(cffrf_pkg::ENABLE_RESET, cffrf_pkg::INTERVAL_RESET);
            1: write_settings(1'b1, 32'd0);
            2: write_settings(1'b0, 32'd5);
            3: write_settings(1'b1, 32'hFFFF_FFFF);
            4: write_settings(1'b1, 32'd20);
            5: write_settings(1'b1, $urandom_range(1, 60));
            6: write_settings(1'b0, $urandom);
            default: write_settings(1'b1, 32'd3);
         endcase
         unique case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 70;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 70;
            end
            default: begin
               sender_idle_pct    = 6;
               receiver_stall_pct = 6;
            end
         endcase
         repeat (250) random_request();
      end

      receiver_stall_pct = 0;
      wait_drained();
      repeat (40) @(negedge clock);
      if (verdicts.error_count == 0 && verdicts.pending_verdicts.size() == 0) begin
         $display("can_frame_forward_rate_filter_unit_tb: done, clean");
      end else begin
         $display("can_frame_forward_rate_filter_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
